[rtl/u8fio_pkg.sv]
`default_nettype none
package u8fio_pkg;

  // payload widths fixed by the channel definition
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ResultW = 32;
  localparam int unsigned CpW     = 21;

  // lead and continuation byte patterns
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Tag  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Tag  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Tag  = 8'hF0;
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;

  // code point ranges per sequence length
  localparam logic [CpW-1:0] Min2      = 21'h000080;
  localparam logic [CpW-1:0] Max2      = 21'h0007FF;
  localparam logic [CpW-1:0] Min3      = 21'h000800;
  localparam logic [CpW-1:0] Max3      = 21'h00FFFF;
  localparam logic [CpW-1:0] Min4      = 21'h010000;
  localparam logic [CpW-1:0] Max4      = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi    = 21'h00DFFF;

  // sequence lengths
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic [ResultW-1:0] first_invalid;
    logic               is_valid;
  } out_beat_t;

endpackage
`default_nettype wire

[rtl/u8fio_if.sv]
`default_nettype none
interface u8fio_in_if
  import u8fio_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface u8fio_out_if
  import u8fio_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ResultW-1:0] first_invalid;
  logic               is_valid;

  modport source (output valid, output first_invalid, output is_valid, input ready);
  modport sink   (input valid, input first_invalid, input is_valid, output ready);
endinterface
`default_nettype wire

[rtl/u8fio_in_stage.sv]
`default_nettype none
module u8fio_in_stage
  import u8fio_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  u8fio_in_if.sink      in_i,
  input  wire logic     take_i,
  output logic          valid_o,
  output in_beat_t      beat_o
);

  logic     valid_q;
  in_beat_t beat_q;

  // room when empty or when the held beat leaves this cycle
  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      beat_q.data_byte <= in_i.data_byte;
      beat_q.last      <= in_i.last;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule
`default_nettype wire

[rtl/u8fio_core.sv]
`default_nettype none
module u8fio_core
  import u8fio_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  in_beat_t      beat_i,
  input  wire logic     room_i,
  output logic          take_o,
  output logic          res_valid_o,
  output out_beat_t     res_o
);

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] errpos_q, errpos_d;
  logic [1:0]             cont_q, cont_d;
  logic [2:0]             len_q, len_d;
  logic [CpW-1:0]         cp_q, cp_d;
  logic                   err_q, err_d;

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] start_n, errpos_n;
  logic [1:0]             cont_n;
  logic [2:0]             len_n;
  logic [CpW-1:0]         cp_n, cp_lo, cp_hi;
  logic                   err_n;
  logic [ByteW-1:0]       b;

  // only the final beat of a buffer needs room in the result register
  assign take_o  = valid_i && (room_i || !beat_i.last);
  assign b       = beat_i.data_byte;
  assign pos_inc = pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  // legal range of the finished sequence
  always_comb begin
    case (len_q)
      SeqLen2: begin cp_lo = Min2; cp_hi = Max2; end
      SeqLen3: begin cp_lo = Min3; cp_hi = Max3; end
      default: begin cp_lo = Min4; cp_hi = Max4; end
    endcase
  end

  // one byte of the decode walk
  always_comb begin
    start_n  = start_q;
    errpos_n = errpos_q;
    cont_n   = cont_q;
    len_n    = len_q;
    cp_n     = cp_q;
    err_n    = err_q;
    if (!err_q) begin
      if (cont_q == 2'd0) begin
        if (!b[7]) begin
          // plain ascii, nothing to track
        end else if ((b & Lead2Mask) == Lead2Tag) begin
          len_n   = SeqLen2;
          cp_n    = {{(CpW-5){1'b0}}, b[4:0]};
          start_n = pos_q;
          cont_n  = 2'd1;
        end else if ((b & Lead3Mask) == Lead3Tag) begin
          len_n   = SeqLen3;
          cp_n    = {{(CpW-4){1'b0}}, b[3:0]};
          start_n = pos_q;
          cont_n  = 2'd2;
        end else if ((b & Lead4Mask) == Lead4Tag) begin
          len_n   = SeqLen4;
          cp_n    = {{(CpW-3){1'b0}}, b[2:0]};
          start_n = pos_q;
          cont_n  = 2'd3;
        end else begin
          err_n    = 1'b1;
          errpos_n = pos_q;
          cont_n   = 2'd0;
        end
      end else if ((b & ContMask) != ContTag) begin
        err_n    = 1'b1;
        errpos_n = start_q;
        cont_n   = 2'd0;
      end else begin
        cp_n   = {cp_q[CpW-7:0], b[5:0]};
        cont_n = cont_q - 2'd1;
        if (cont_n == 2'd0) begin
          if (cp_n < cp_lo || cp_n > cp_hi || (cp_n >= SurrLo && cp_n <= SurrHi)) begin
            err_n    = 1'b1;
            errpos_n = start_q;
            cont_n   = 2'd0;
          end
        end
      end
    end
    // sequence cut short by the end of the buffer
    if (beat_i.last && !err_n && cont_n != 2'd0) begin
      err_n    = 1'b1;
      errpos_n = start_n;
      cont_n   = 2'd0;
    end
  end

  // commit or clear at the buffer end
  always_comb begin
    pos_d    = pos_q;
    start_d  = start_q;
    errpos_d = errpos_q;
    cont_d   = cont_q;
    len_d    = len_q;
    cp_d     = cp_q;
    err_d    = err_q;
    if (take_o) begin
      if (beat_i.last) begin
        pos_d    = '0;
        start_d  = '0;
        errpos_d = '0;
        cont_d   = '0;
        len_d    = '0;
        cp_d     = '0;
        err_d    = 1'b0;
      end else begin
        pos_d    = pos_inc;
        start_d  = start_n;
        errpos_d = errpos_n;
        cont_d   = cont_n;
        len_d    = len_n;
        cp_d     = cp_n;
        err_d    = err_n;
      end
    end
  end

  assign res_valid_o         = take_o && beat_i.last;
  assign res_o.first_invalid = ResultW'(err_n ? errpos_n : pos_inc);
  assign res_o.is_valid      = !err_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      start_q  <= '0;
      errpos_q <= '0;
      cont_q   <= '0;
      len_q    <= '0;
      cp_q     <= '0;
      err_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      start_q  <= start_d;
      errpos_q <= errpos_d;
      cont_q   <= cont_d;
      len_q    <= len_d;
      cp_q     <= cp_d;
      err_q    <= err_d;
    end
  end

  // buffer end returns the walker to its idle state
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && beat_i.last |=> pos_q == '0 && !err_q && cont_q == 2'd0)
    else $error("state not cleared after final beat");

  // a latched error holds until the buffer ends
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && !(take_o && beat_i.last) |=> err_q && $stable(errpos_q))
    else $error("latched error lost");

  // no continuation is owed once an error is latched
  a_err_no_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> cont_q == 2'd0)
    else $error("continuation owed after error");

  // owed continuations never reach the sequence length
  a_cont_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cont_q != 2'd0 |-> {1'b0, cont_q} < len_q)
    else $error("continuation count exceeds sequence length");

endmodule
`default_nettype wire

[rtl/u8fio_out_stage.sv]
`default_nettype none
module u8fio_out_stage
  import u8fio_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  out_beat_t     res_i,
  output logic          room_o,
  u8fio_out_if.source   out_o
);

  logic      valid_q;
  out_beat_t res_q;

  // free when empty or when the held result is taken this cycle
  assign room_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.first_invalid = res_q.first_invalid;
  assign out_o.is_valid      = res_q.is_valid;

endmodule
`default_nettype wire

[rtl/utf8_first_invalid_offset.sv]
// Strict UTF-8 checker for a byte stream, one buffer after another.
// Input channel in_i: one byte per beat with a last flag on the final byte
// of a buffer. Output channel out_o: one beat per buffer, carrying the
// offset of the lead byte of the first bad sequence (or the buffer length
// when all is well) and an is_valid flag.
// Throughput: one byte per clock, sustained; buffers may follow each other
// with no gap. A byte passes an input register, then one step of decode
// logic that updates the sequence state, then the result register.
// Once the final byte is accepted into the input register, the result beat
// is loaded into the result register, from which out_o presents it.
// When the receiver stalls, the result register holds its beat; the next
// buffer keeps streaming until a second result is due, then in_i.ready
// drops until out_o takes the held beat.
// Reset empties both registers and clears the offset and error state, so
// the first byte after reset is offset zero of a new buffer.
// OFFSET_BITS sets the offset counter width; reported offsets are the low
// 32 bits of the counter (zero-extended when narrower).
`default_nettype none
module utf8_first_invalid_offset
  import u8fio_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  u8fio_in_if.sink     in_i,
  u8fio_out_if.source  out_o
);

  logic      in_valid;
  in_beat_t  in_beat;
  logic      take;
  logic      room;
  logic      res_valid;
  out_beat_t res;

  // input register
  u8fio_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (in_valid),
    .beat_o  (in_beat)
  );

  // sequence state and decode step
  u8fio_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid),
    .beat_i      (in_beat),
    .room_i      (room),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  u8fio_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .res_i  (res),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire
